FILE: hdl/ord_pkg.sv
// Shared constants, codes and helper functions of the overwriting ring deque.
package ord_pkg;

  localparam int DEPTH      = 16;
  localparam int ELEM_BYTES = 8;

  localparam int WORD_W = 64;
  localparam int LEN_W  = 4;
  localparam int IDX_W  = 5;
  localparam int OP_W   = 3;
  localparam int EV_W   = 3;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LOG_W  = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
  localparam int SLOT_W = PTR_W + 2;
  localparam int ENTRY_W = WORD_W + LEN_W;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_AT    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
  localparam logic [EV_W-1:0] EV_PUSH_FRONT = 3'd1;
  localparam logic [EV_W-1:0] EV_PUSH_BACK  = 3'd2;
  localparam logic [EV_W-1:0] EV_POP_FRONT  = 3'd3;
  localparam logic [EV_W-1:0] EV_POP_BACK   = 3'd4;
  localparam logic [EV_W-1:0] EV_CLEAR      = 3'd5;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  function automatic logic [WORD_W-1:0] byte_mask(logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W / 8; b++) begin
      m[8*b +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: hdl/ord_if.sv
// Request and response channel interfaces of the overwriting ring deque.
interface ord_req_if;
  import ord_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [WORD_W-1:0] data_word;
  logic [LEN_W-1:0]  data_len;
  logic signed [IDX_W-1:0] index;

  modport source (output valid, opcode, data_word, data_len, index, input ready);
  modport sink   (input valid, opcode, data_word, data_len, index, output ready);
endinterface

interface ord_rsp_if;
  import ord_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  count;
  logic              read_valid;
  logic [WORD_W-1:0] read_data;
  logic [LEN_W-1:0]  read_len;
  logic              full_evict;
  logic [EV_W-1:0]   event_code;

  modport source (output valid, count, read_valid, read_data, read_len, full_evict,
                  event_code, input ready);
  modport sink   (input valid, count, read_valid, read_data, read_len, full_evict,
                  event_code, output ready);
endinterface

FILE: hdl/ord_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ord_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/overwriting_ring_deque.sv
// Top level of the overwriting ring deque: pointer control, entry RAM and response register.
//
// Usage:
//   req carries one request per valid/ready handshake: opcode, data_word, data_len, index.
//   rsp returns exactly one response per request, in order: count, read_valid,
//   read_data, read_len, full_evict, event_code.
//   Responses are registered: a request accepted at a clock edge has its response
//   valid after that edge. Throughput is one request per cycle while rsp.ready is high;
//   pointers, count and the single entry RAM access (one write for a push, one read
//   for read_at) finish in the accepting cycle; RAM read data lands in its output register.
//   The response register holds its contents while rsp.ready is low; req.ready is
//   high when the response register is empty or being drained in the same cycle,
//   so a stalled receiver holds back at most one response.
//   Reset (rst, synchronous) empties the deque and drops any pending response.
//   Entry RAM contents are not cleared; only live entries are ever read.
//   A push into a full deque first evicts the back entry and reports full_evict.
module overwriting_ring_deque (
  input  logic clk,
  input  logic rst,
  ord_req_if.sink   req,
  ord_rsp_if.source rsp
);
  import ord_pkg::*;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic             rsp_valid;
  logic             rd_valid;
  logic             evict, evict_next;
  logic [EV_W-1:0]  ev, ev_next;

  logic             accept;
  logic [LEN_W-1:0] len_sat;
  logic             full;
  logic [PTR_W-1:0] tail_adj;
  logic [CNT_W-1:0] count_adj;
  logic             push_do;
  logic [PTR_W-1:0] wslot;
  logic             read_hit;

  logic signed [LOG_W-1:0] idx_ext;
  logic signed [LOG_W-1:0] cnt_ext;
  logic signed [LOG_W-1:0] logical;
  logic [SLOT_W-1:0]       slot_sum;
  logic [PTR_W-1:0]        rslot;

  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;

  assign len_sat   = (req.data_len > LEN_W'(ELEM_BYTES)) ? LEN_W'(ELEM_BYTES) : req.data_len;
  assign full      = (count == CNT_W'(DEPTH));
  assign tail_adj  = full ? ptr_inc(tail) : tail;
  assign count_adj = full ? count - CNT_W'(1) : count;

  // read_at position to physical slot
  assign idx_ext  = LOG_W'(req.index);
  assign cnt_ext  = signed'({{(LOG_W - CNT_W){1'b0}}, count});
  assign logical  = req.index[IDX_W-1] ? idx_ext + cnt_ext : idx_ext;
  assign read_hit = (req.opcode == OP_READ_AT) && (count != '0)
                    && !logical[LOG_W-1] && (logical < cnt_ext);
  assign slot_sum = SLOT_W'(head) + SLOT_W'(DEPTH - 1) - SLOT_W'(logical);
  assign rslot    = (slot_sum >= SLOT_W'(DEPTH)) ? PTR_W'(slot_sum - SLOT_W'(DEPTH))
                                                 : PTR_W'(slot_sum);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    evict_next = 1'b0;
    ev_next    = EV_NONE;
    push_do    = 1'b0;
    wslot      = head;
    case (req.opcode)
      OP_PUSH_FRONT: begin
        if (len_sat != '0) begin
          push_do    = 1'b1;
          evict_next = full;
          tail_next  = tail_adj;
          wslot      = head;
          head_next  = ptr_inc(head);
          count_next = count_adj + CNT_W'(1);
          ev_next    = EV_PUSH_FRONT;
        end
      end
      OP_PUSH_BACK: begin
        if (len_sat != '0) begin
          push_do    = 1'b1;
          evict_next = full;
          tail_next  = ptr_dec(tail_adj);
          wslot      = ptr_dec(tail_adj);
          count_next = count_adj + CNT_W'(1);
          ev_next    = EV_PUSH_BACK;
        end
      end
      OP_POP_FRONT: begin
        if (count != '0) begin
          head_next  = ptr_dec(head);
          count_next = count - CNT_W'(1);
          ev_next    = EV_POP_FRONT;
        end
      end
      OP_POP_BACK: begin
        if (count != '0) begin
          tail_next  = ptr_inc(tail);
          count_next = count - CNT_W'(1);
          ev_next    = EV_POP_BACK;
        end
      end
      OP_CLEAR: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
        ev_next    = (count != '0) ? EV_CLEAR : EV_NONE;
      end
      default: begin
      end
    endcase
  end

  assign ram_wdata = {len_sat, req.data_word & byte_mask(len_sat)};

  ord_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (accept && push_do),
    .waddr (wslot),
    .wdata (ram_wdata),
    .re    (accept && read_hit),
    .raddr (rslot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        head      <= head_next;
        tail      <= tail_next;
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_valid <= read_hit;
      evict    <= evict_next;
      ev       <= ev_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.count      = count;
  assign rsp.read_valid = rd_valid;
  assign rsp.read_data  = rd_valid ? ram_rdata[WORD_W-1:0] : '0;
  assign rsp.read_len   = rd_valid ? ram_rdata[ENTRY_W-1:WORD_W] : '0;
  assign rsp.full_evict = evict;
  assign rsp.event_code = ev;

endmodule
